@@ rtl/core/ist_pkg.sv @@
// shared types and constants of the interval set tracker
`timescale 1ns / 1ps
`default_nettype none
package ist_pkg;

  // fixed field widths of the item channels
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_COORD_W = 32;
  localparam int unsigned STATUS_W   = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // flags that travel down the chain with the scan token
  typedef struct packed {
    logic act;
    logic hit;
    logic covered;
    logic span_hit;
    logic pend;
  } ist_ctl_t;

  // command context broadcast to every cell
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             pass2;
    logic             full;
  } ist_bc_t;

endpackage
`default_nettype wire

@@ rtl/core/ist_if.sv @@
// item channel interfaces of the interval set tracker
`timescale 1ns / 1ps
`default_nettype none
interface ist_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] range_left;
  logic [31:0] range_right;

  modport source (output valid, output command, output range_left, output range_right,
                  input ready);
  modport sink (input valid, input command, input range_left, input range_right,
                output ready);
endinterface

interface ist_out_if #(
  parameter int unsigned CNT_W = 7
);
  logic             valid;
  logic             ready;
  logic             covered;
  logic [1:0]       status;
  logic [CNT_W-1:0] interval_count;

  modport source (output valid, output covered, output status, output interval_count,
                  input ready);
  modport sink (input valid, input covered, input status, input interval_count,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/ist_cell.sv @@
// one interval slot of the chain, updated as the scan token passes
`timescale 1ns / 1ps
`default_nettype none
module ist_cell #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned CNT_W      = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ist_pkg::ist_bc_t      bc_i,
  input  logic [COORD_BITS-1:0] lo_i,
  input  logic [COORD_BITS-1:0] hi_i,
  input  logic [COORD_BITS-1:0] wlo_i,
  input  logic [COORD_BITS-1:0] whi_i,
  input  ist_pkg::ist_ctl_t     ctl_i,
  input  logic [COORD_BITS-1:0] nlo_i,
  input  logic [COORD_BITS-1:0] nhi_i,
  input  logic [COORD_BITS-1:0] span_end_i,
  input  logic [CNT_W-1:0]      cnt_i,
  output ist_pkg::ist_ctl_t     ctl_o,
  output logic [COORD_BITS-1:0] nlo_o,
  output logic [COORD_BITS-1:0] nhi_o,
  output logic [COORD_BITS-1:0] span_end_o,
  output logic [CNT_W-1:0]      cnt_o
);
  import ist_pkg::*;

  logic                  v_q, v_d;
  logic [COORD_BITS-1:0] s_q, s_d, e_q, e_d;
  ist_ctl_t              ctl_q, ctl_d;
  logic [COORD_BITS-1:0] nlo_q, nlo_d, nhi_q, nhi_d, se_q, se_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // slot update and accumulation while the token sits here
  always_comb begin
    v_d   = v_q;
    s_d   = s_q;
    e_d   = e_q;
    ctl_d = ctl_i;
    nlo_d = nlo_i;
    nhi_d = nhi_i;
    se_d  = span_end_i;
    cnt_d = cnt_i;
    if (ctl_i.act) begin
      if (!bc_i.pass2) begin
        case (bc_i.cmd)
          CMD_ADD: begin
            if (v_q && s_q <= hi_i && e_q >= lo_i) begin
              nlo_d     = (s_q < nlo_i) ? s_q : nlo_i;
              nhi_d     = (e_q > nhi_i) ? e_q : nhi_i;
              ctl_d.hit = 1'b1;
              v_d       = 1'b0;
            end
          end
          CMD_REMOVE: begin
            if (v_q && s_q < hi_i && e_q > lo_i) begin
              if (s_q < lo_i && e_q > hi_i) begin
                ctl_d.span_hit = 1'b1;
                se_d           = e_q;
                if (!bc_i.full) begin
                  e_d = lo_i;
                end
              end else if (s_q < lo_i) begin
                e_d = lo_i;
              end else if (e_q > hi_i) begin
                s_d = hi_i;
              end else begin
                v_d = 1'b0;
              end
            end
          end
          CMD_QUERY: begin
            if (v_q && s_q <= lo_i && e_q >= hi_i) begin
              ctl_d.covered = 1'b1;
            end
          end
          default: ;
        endcase
        cnt_d = cnt_i + CNT_W'(v_d);
      end else if (ctl_i.pend && !v_q) begin
        // first free slot takes the pending entry
        v_d        = 1'b1;
        s_d        = wlo_i;
        e_d        = whi_i;
        ctl_d.pend = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      ctl_q <= '0;
    end else begin
      v_q   <= v_d;
      ctl_q <= ctl_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    e_q   <= e_d;
    nlo_q <= nlo_d;
    nhi_q <= nhi_d;
    se_q  <= se_d;
    cnt_q <= cnt_d;
  end

  assign ctl_o      = ctl_q;
  assign nlo_o      = nlo_q;
  assign nhi_o      = nhi_q;
  assign span_end_o = se_q;
  assign cnt_o      = cnt_q;

endmodule
`default_nettype wire

@@ rtl/core/interval_set_tracker.sv @@
// top level of the interval set tracker: sequencer and chain of slot cells
`timescale 1ns / 1ps
`default_nettype none
// Keeps up to MAX_INTERVALS disjoint half-open intervals in a chain of slot
// cells; a scan token walks the chain one cell per cycle. One item at a time:
// an invalid range or unknown command needs no walk; a query, a remove
// without a split, or an add or a split refused on a full table takes one
// walk of the chain, and an add or a splitting remove takes a second walk,
// which places the merged or split-off interval in the first free slot.
// Each item gives one result, held in an output register until taken.
module interval_set_tracker #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned COORD_BITS    = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ist_in_if.sink    in_i,
  ist_out_if.source out_o
);
  import ist_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN1 = 2'd1;
  localparam logic [1:0] S_SCAN2 = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic                  start_q, start_d;
  logic [CMD_W-1:0]      cmd_q;
  logic [COORD_BITS-1:0] lo_q, hi_q, wlo_q, wlo_d, whi_q, whi_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  res_cov_q, res_cov_d;
  logic [STATUS_W-1:0]   res_st_q, res_st_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_cov_q;
  logic [STATUS_W-1:0]   out_st_q;
  logic [CNT_W-1:0]      out_cnt_q;
  logic                  out_load;

  logic                  accept;
  logic [COORD_BITS-1:0] in_lo, in_hi;
  logic                  in_bad;

  ist_bc_t               bc;
  ist_ctl_t              ctl_w   [MAX_INTERVALS+1];
  logic [COORD_BITS-1:0] nlo_w   [MAX_INTERVALS+1];
  logic [COORD_BITS-1:0] nhi_w   [MAX_INTERVALS+1];
  logic [COORD_BITS-1:0] se_w    [MAX_INTERVALS+1];
  logic [CNT_W-1:0]      cnt_w   [MAX_INTERVALS+1];
  ist_ctl_t              last;

  // input side
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_lo      = COORD_BITS'(in_i.range_left);
  assign in_hi      = COORD_BITS'(in_i.range_right);
  assign in_bad     = (in_i.command != CMD_ADD && in_i.command != CMD_REMOVE &&
                       in_i.command != CMD_QUERY) || (in_lo >= in_hi);

  // broadcast context and token injection at the head of the chain
  assign bc.cmd   = cmd_q;
  assign bc.pass2 = (state_q == S_SCAN2);
  assign bc.full  = (count_q == CNT_W'(MAX_INTERVALS));

  assign ctl_w[0].act      = start_q;
  assign ctl_w[0].hit      = 1'b0;
  assign ctl_w[0].covered  = 1'b0;
  assign ctl_w[0].span_hit = 1'b0;
  assign ctl_w[0].pend     = (state_q == S_SCAN2);
  assign nlo_w[0]          = lo_q;
  assign nhi_w[0]          = hi_q;
  assign se_w[0]           = hi_q;
  assign cnt_w[0]          = '0;

  // chain of slot cells
  for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
    ist_cell #(
      .COORD_BITS(COORD_BITS),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .bc_i      (bc),
      .lo_i      (lo_q),
      .hi_i      (hi_q),
      .wlo_i     (wlo_q),
      .whi_i     (whi_q),
      .ctl_i     (ctl_w[g]),
      .nlo_i     (nlo_w[g]),
      .nhi_i     (nhi_w[g]),
      .span_end_i(se_w[g]),
      .cnt_i     (cnt_w[g]),
      .ctl_o     (ctl_w[g+1]),
      .nlo_o     (nlo_w[g+1]),
      .nhi_o     (nhi_w[g+1]),
      .span_end_o(se_w[g+1]),
      .cnt_o     (cnt_w[g+1])
    );
  end

  assign last = ctl_w[MAX_INTERVALS];

  // sequencer
  always_comb begin
    state_d   = state_q;
    start_d   = 1'b0;
    wlo_d     = wlo_q;
    whi_d     = whi_q;
    count_d   = count_q;
    res_cov_d = res_cov_q;
    res_st_d  = res_st_q;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_cov_d = 1'b0;
          if (in_bad) begin
            res_st_d = ST_INVALID;
            state_d  = S_DONE;
          end else begin
            start_d = 1'b1;
            state_d = S_SCAN1;
          end
        end
      end
      S_SCAN1: begin
        if (last.act) begin
          res_st_d = ST_OK;
          state_d  = S_DONE;
          count_d  = cnt_w[MAX_INTERVALS];
          case (cmd_q)
            CMD_ADD: begin
              if (!last.hit && bc.full) begin
                res_st_d = ST_FULL;
              end else begin
                wlo_d   = nlo_w[MAX_INTERVALS];
                whi_d   = nhi_w[MAX_INTERVALS];
                count_d = cnt_w[MAX_INTERVALS] + CNT_W'(1);
                start_d = 1'b1;
                state_d = S_SCAN2;
              end
            end
            CMD_REMOVE: begin
              if (last.span_hit) begin
                if (bc.full) begin
                  res_st_d = ST_FULL;
                end else begin
                  wlo_d   = hi_q;
                  whi_d   = se_w[MAX_INTERVALS];
                  count_d = cnt_w[MAX_INTERVALS] + CNT_W'(1);
                  start_d = 1'b1;
                  state_d = S_SCAN2;
                end
              end
            end
            default: begin
              res_cov_d = last.covered;
            end
          endcase
        end
      end
      S_SCAN2: begin
        if (last.act) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_i.command;
      lo_q  <= in_lo;
      hi_q  <= in_hi;
    end
    wlo_q     <= wlo_d;
    whi_q     <= whi_d;
    res_cov_q <= res_cov_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_cov_q <= res_cov_q;
      out_st_q  <= res_st_q;
      out_cnt_q <= count_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.covered        = out_cov_q;
  assign out_o.status         = out_st_q;
  assign out_o.interval_count = out_cnt_q;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_INTERVALS))
    else $error("interval count above capacity");
  a_start_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> !start_q)
    else $error("scan token injected on consecutive cycles");
  a_write_placed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN2 && last.act) |-> !last.pend)
    else $error("pending entry found no free slot");
  a_scan_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.act |-> (state_q == S_SCAN1 || state_q == S_SCAN2))
    else $error("scan token left the chain outside a scan");
`endif

endmodule
`default_nettype wire
